// File: hdl/tpc_pkg.sv
// shared types and constants for the triangle pixel coverage block
// no dependencies; every other file imports this package
package tpc_pkg;

    localparam int VERTEX_W  = 16;
    localparam int PIXEL_W   = 13;
    localparam int COLOR_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int NUM_EDGES = 3;
    localparam int NUM_VERTS = 3;
    localparam int EDGE_W    = VERTEX_W + 1;
    localparam int DIFF_W    = VERTEX_W + 2;
    localparam int PROD_W    = DIFF_W + EDGE_W;
    localparam int SUM_W     = PROD_W + 1;

    // cycles from a vertex write until the edge setup is settled
    localparam int SETUP_LAT = 3;
    localparam int SETUP_CNT_W = $clog2(SETUP_LAT + 1);

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR = 3'd6;

    // facing sign codes
    typedef logic [1:0] facing_t;
    localparam facing_t FACING_ZERO = 2'b00;
    localparam facing_t FACING_POS  = 2'b01;
    localparam facing_t FACING_NEG  = 2'b11;

    // edge k runs from vertex EDGE_P[k] to EDGE_Q[k], opposite EDGE_O[k]
    localparam int EDGE_P [NUM_EDGES] = '{1, 0, 0};
    localparam int EDGE_Q [NUM_EDGES] = '{2, 2, 1};
    localparam int EDGE_O [NUM_EDGES] = '{0, 1, 2};

    typedef struct packed {
        logic [EDGE_W-1:0] nx;
        logic [EDGE_W-1:0] ny;
        logic [EDGE_W-1:0] mx;
        logic [EDGE_W-1:0] my;
        facing_t           facing;
    } edge_t;

    typedef struct packed {
        logic                busy;
        logic                all_zero;
        logic [COLOR_W-1:0]  fill_color;
    } setup_status_t;

endpackage

// File: hdl/tpc_ifs.sv
// valid/ready channel interfaces for pixel input, pixel output and config writes
// depends on tpc_pkg
interface tpc_pixel_in_if
    import tpc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_x;
    logic [PIXEL_W-1:0] pixel_y;
    logic [COLOR_W-1:0] old_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output old_pixel,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input old_pixel,
                    output ready);
endinterface

interface tpc_pixel_out_if
    import tpc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               covered;
    logic [COLOR_W-1:0] new_pixel;

    modport source (output valid, output covered, output new_pixel, input ready);
    modport sink   (input valid, input covered, input new_pixel, output ready);
endinterface

interface tpc_cfg_if
    import tpc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/tpc_edge_setup.sv
// vertex and fill registers plus the three-stage edge setup pipeline
// depends on tpc_pkg and tpc_ifs
module tpc_edge_setup
    import tpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    tpc_cfg_if.sink              cfg,
    output edge_t [NUM_EDGES-1:0] edges,
    output setup_status_t        status
);

    logic [VERTEX_W-1:0] vx_reg [NUM_VERTS];
    logic [VERTEX_W-1:0] vy_reg [NUM_VERTS];
    logic [COLOR_W-1:0]  fill_reg;
    logic [SETUP_CNT_W-1:0] busy_cnt_reg;
    logic [SETUP_CNT_W-1:0] busy_cnt_next;
    logic                cfg_fire;
    logic                vertex_write;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    always_comb
    begin
        vertex_write = 1'b0;
        if (cfg_fire)
        begin
            unique case (cfg.index)
                REG_VERTEX_A_X, REG_VERTEX_A_Y, REG_VERTEX_B_X,
                REG_VERTEX_B_Y, REG_VERTEX_C_X, REG_VERTEX_C_Y: vertex_write = 1'b1;
                default:                                         vertex_write = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < NUM_VERTS; v++)
            begin
                vx_reg[v] <= '0;
                vy_reg[v] <= '0;
            end
            fill_reg <= '0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg.index)
                REG_VERTEX_A_X: vx_reg[0] <= cfg.data[VERTEX_W-1:0];
                REG_VERTEX_A_Y: vy_reg[0] <= cfg.data[VERTEX_W-1:0];
                REG_VERTEX_B_X: vx_reg[1] <= cfg.data[VERTEX_W-1:0];
                REG_VERTEX_B_Y: vy_reg[1] <= cfg.data[VERTEX_W-1:0];
                REG_VERTEX_C_X: vx_reg[2] <= cfg.data[VERTEX_W-1:0];
                REG_VERTEX_C_Y: vy_reg[2] <= cfg.data[VERTEX_W-1:0];
                REG_FILL_COLOR: fill_reg  <= cfg.data[COLOR_W-1:0];
                default:        ;
            endcase
        end
    end

    // hold off pixels until the new edge setup reaches the facing registers
    always_comb
    begin
        busy_cnt_next = busy_cnt_reg;
        if (vertex_write)
            busy_cnt_next = SETUP_CNT_W'(SETUP_LAT);
        else if (busy_cnt_reg != '0)
            busy_cnt_next = busy_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_cnt_reg <= '0;
        else
            busy_cnt_reg <= busy_cnt_next;
    end

    facing_t [NUM_EDGES-1:0] facing_reg;

    for (genvar k = 0; k < NUM_EDGES; k++)
    begin : g_edge
        logic signed [EDGE_W-1:0] nx_next, ny_next, mx_next, my_next;
        logic signed [DIFF_W-1:0] dox_next, doy_next;
        logic signed [EDGE_W-1:0] nx_reg, ny_reg, mx_reg, my_reg;
        logic signed [DIFF_W-1:0] dox_reg, doy_reg;
        logic signed [PROD_W-1:0] prx_reg, pry_reg;
        logic signed [SUM_W-1:0]  d_sum;
        logic [VERTEX_W-1:0]      p_x, p_y, q_x, q_y, o_x, o_y;

        assign p_x = vx_reg[EDGE_P[k]];
        assign p_y = vy_reg[EDGE_P[k]];
        assign q_x = vx_reg[EDGE_Q[k]];
        assign q_y = vy_reg[EDGE_Q[k]];
        assign o_x = vx_reg[EDGE_O[k]];
        assign o_y = vy_reg[EDGE_O[k]];

        // normal is perp of q - p, midpoint kept doubled
        assign nx_next  = $signed({p_y[VERTEX_W-1], p_y}) - $signed({q_y[VERTEX_W-1], q_y});
        assign ny_next  = $signed({q_x[VERTEX_W-1], q_x}) - $signed({p_x[VERTEX_W-1], p_x});
        assign mx_next  = $signed({p_x[VERTEX_W-1], p_x}) + $signed({q_x[VERTEX_W-1], q_x});
        assign my_next  = $signed({p_y[VERTEX_W-1], p_y}) + $signed({q_y[VERTEX_W-1], q_y});
        assign dox_next = $signed({o_x[VERTEX_W-1], o_x, 1'b0})
                        - $signed({mx_next[EDGE_W-1], mx_next});
        assign doy_next = $signed({o_y[VERTEX_W-1], o_y, 1'b0})
                        - $signed({my_next[EDGE_W-1], my_next});

        assign d_sum = $signed({prx_reg[PROD_W-1], prx_reg})
                     + $signed({pry_reg[PROD_W-1], pry_reg});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                nx_reg        <= '0;
                ny_reg        <= '0;
                mx_reg        <= '0;
                my_reg        <= '0;
                dox_reg       <= '0;
                doy_reg       <= '0;
                prx_reg       <= '0;
                pry_reg       <= '0;
                facing_reg[k] <= FACING_ZERO;
            end
            else
            begin
                nx_reg  <= nx_next;
                ny_reg  <= ny_next;
                mx_reg  <= mx_next;
                my_reg  <= my_next;
                dox_reg <= dox_next;
                doy_reg <= doy_next;
                prx_reg <= dox_reg * nx_reg;
                pry_reg <= doy_reg * ny_reg;
                if (d_sum > 0)
                    facing_reg[k] <= FACING_POS;
                else if (d_sum < 0)
                    facing_reg[k] <= FACING_NEG;
                else
                    facing_reg[k] <= FACING_ZERO;
            end
        end

        assign edges[k].nx     = nx_reg;
        assign edges[k].ny     = ny_reg;
        assign edges[k].mx     = mx_reg;
        assign edges[k].my     = my_reg;
        assign edges[k].facing = facing_reg[k];
    end

    assign status.busy       = (busy_cnt_reg != '0);
    assign status.all_zero   = (facing_reg[0] == FACING_ZERO) && (facing_reg[1] == FACING_ZERO)
                            && (facing_reg[2] == FACING_ZERO);
    assign status.fill_color = fill_reg;

endmodule

// File: hdl/triangle_pixel_coverage_top.sv
// pipeline: an accepted pixel word passes stages s1, s2 and s3, then the output register holds its result word
// throughput: one pixel word per cycle while the output is ready; after a vertex write the input holds off
//   while the edge setup pipeline (normals, midpoints, facing products) settles
// reset: vertices and fill color clear to zero, all facings zero, so every pixel is covered
// top level: pixel test pipeline around the edge setup unit
// depends on tpc_pkg, tpc_ifs and tpc_edge_setup
module triangle_pixel_coverage_top
    import tpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tpc_cfg_if.sink       cfg,
    tpc_pixel_in_if.sink  pixel_in,
    tpc_pixel_out_if.source pixel_out
);

    edge_t [NUM_EDGES-1:0] edges;
    setup_status_t         status;

    tpc_edge_setup u_setup (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .edges  (edges),
        .status (status)
    );

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_en, s2_en, s3_en, out_en;
    logic in_fire;

    logic [COLOR_W-1:0] s1_old_reg, s2_old_reg, s3_old_reg;
    logic [NUM_EDGES-1:0] pass_next, pass_reg;
    logic               covered_reg;
    logic [COLOR_W-1:0] new_pixel_reg;

    // each stage moves when empty or when the next one moves
    assign out_en = !out_valid_reg || pixel_out.ready;
    assign s3_en  = !s3_valid_reg || out_en;
    assign s2_en  = !s2_valid_reg || s3_en;
    assign s1_en  = !s1_valid_reg || s2_en;

    assign pixel_in.ready = s1_en && !status.busy;
    assign in_fire        = pixel_in.valid && pixel_in.ready;

    logic signed [DIFF_W-1:0] dx_reg [NUM_EDGES];
    logic signed [DIFF_W-1:0] dy_reg [NUM_EDGES];
    logic signed [PROD_W-1:0] prx_reg [NUM_EDGES];
    logic signed [PROD_W-1:0] pry_reg [NUM_EDGES];

    for (genvar k = 0; k < NUM_EDGES; k++)
    begin : g_test
        logic signed [DIFF_W-1:0] dx_next, dy_next;
        logic signed [SUM_W-1:0]  t_sum;

        // 2*pixel - doubled midpoint
        assign dx_next = $signed({{(DIFF_W-PIXEL_W-1){1'b0}}, pixel_in.pixel_x, 1'b0})
                       - $signed({edges[k].mx[EDGE_W-1], edges[k].mx});
        assign dy_next = $signed({{(DIFF_W-PIXEL_W-1){1'b0}}, pixel_in.pixel_y, 1'b0})
                       - $signed({edges[k].my[EDGE_W-1], edges[k].my});

        assign t_sum = $signed({prx_reg[k][PROD_W-1], prx_reg[k]})
                     + $signed({pry_reg[k][PROD_W-1], pry_reg[k]});

        always_comb
        begin
            if (edges[k].facing == FACING_POS)
                pass_next[k] = !t_sum[SUM_W-1];
            else if (edges[k].facing == FACING_NEG)
                pass_next[k] = t_sum[SUM_W-1] || (t_sum == '0);
            else
                pass_next[k] = 1'b1;
        end

        always_ff @(posedge clk)
        begin
            if (s1_en)
            begin
                dx_reg[k] <= dx_next;
                dy_reg[k] <= dy_next;
            end
            if (s2_en)
            begin
                prx_reg[k] <= dx_reg[k] * $signed(edges[k].nx);
                pry_reg[k] <= dy_reg[k] * $signed(edges[k].ny);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= in_fire;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (s3_en)
                s3_valid_reg <= s2_valid_reg;
            if (out_en)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
            s1_old_reg <= pixel_in.old_pixel;
        if (s2_en)
            s2_old_reg <= s1_old_reg;
        if (s3_en)
        begin
            s3_old_reg <= s2_old_reg;
            pass_reg   <= pass_next;
        end
        if (out_en)
        begin
            covered_reg   <= &pass_reg;
            new_pixel_reg <= (&pass_reg) ? status.fill_color : s3_old_reg;
        end
    end

    assign pixel_out.valid     = out_valid_reg;
    assign pixel_out.covered   = covered_reg;
    assign pixel_out.new_pixel = new_pixel_reg;

    // a vertex write must keep the next cycle free of pixel words
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready && (cfg.index != REG_FILL_COLOR) && !cfg.index[CFG_IDX_W-1]
            || cfg.valid && cfg.ready && (cfg.index == REG_VERTEX_C_X
            || cfg.index == REG_VERTEX_C_Y))
        |=> !(pixel_in.valid && pixel_in.ready))
        else $error("pixel word accepted during edge setup");

    // a stalled first stage keeps its difference terms
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_en) |=> (s1_valid_reg && $stable(dx_reg[0]) && $stable(dy_reg[0])))
        else $error("first stage lost data on stall");

    // with all facings zero every word leaving stage three is covered
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && out_en && status.all_zero && !status.busy) |=> covered_reg)
        else $error("degenerate triangle did not cover pixel");

endmodule

// File: dv/tb_triangle_pixel_coverage_top.sv
`timescale 1ns / 1ps
// self-checking testbench for triangle_pixel_coverage_top: directed and random pixel words
// checked against an edge-function coverage predictor; depends on tpc_pkg and tpc_ifs
module tb_triangle_pixel_coverage_top;
    import tpc_pkg::*;

    localparam int PIPE_LAT       = 4;
    localparam int DRAIN_CYCLES   = PIPE_LAT + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_LEN   = 64;
    localparam int HOLD_OFF_AFTER = 300;
    localparam int IDLE_PCT       = 15;
    localparam int PHASE_ITEMS    = 115;

    // index past the last register, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [CFG_IDX_W-1:0] VERTEX_REGS [6] = '{REG_VERTEX_A_X, REG_VERTEX_A_Y,
        REG_VERTEX_B_X, REG_VERTEX_B_Y, REG_VERTEX_C_X, REG_VERTEX_C_Y};

    typedef struct {
        logic [PIXEL_W-1:0] x;
        logic [PIXEL_W-1:0] y;
        logic [COLOR_W-1:0] old_rgba;
    } pixel_word_t;

    typedef struct {
        logic               covered;
        logic [COLOR_W-1:0] rgba;
    } coverage_word_t;

    logic clk = 1'b0;
    logic rst_n;

    tpc_cfg_if       cfg_bus ();
    tpc_pixel_in_if  pix_in ();
    tpc_pixel_out_if pix_out ();

    triangle_pixel_coverage_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_bus),
        .pixel_in  (pix_in),
        .pixel_out (pix_out)
    );

    always #6 clk = ~clk;

    // predictor copy of the triangle setup
    int             vert_x [NUM_VERTS];
    int             vert_y [NUM_VERTS];
    logic [COLOR_W-1:0] fill_rgba;
    longint         edge_nx [NUM_EDGES];
    longint         edge_ny [NUM_EDGES];
    longint         edge_mx [NUM_EDGES];
    longint         edge_my [NUM_EDGES];
    facing_t        edge_face [NUM_EDGES];

    pixel_word_t    pending_pixels [$];
    coverage_word_t expected_results [$];
    coverage_word_t out_word;
    coverage_word_t want_word;

    logic pixel_taken;
    bit   calm;
    bit   pressure_done;
    int   hold_cnt;
    int   quiet_cycles;
    int   fail_count;
    int   pixels_sent;
    int   results_seen;
    int   covered_seen;
    int   cfg_writes;

    function automatic void derive_edge_setup();
        int     p;
        int     q;
        int     o;
        longint d;
        for (int k = 0; k < NUM_EDGES; k++) begin
            p = EDGE_P[k];
            q = EDGE_Q[k];
            o = EDGE_O[k];
            edge_nx[k] = -(longint'(vert_y[q]) - vert_y[p]);
            edge_ny[k] = longint'(vert_x[q]) - vert_x[p];
            edge_mx[k] = longint'(vert_x[p]) + vert_x[q];
            edge_my[k] = longint'(vert_y[p]) + vert_y[q];
            d = (2 * longint'(vert_x[o]) - edge_mx[k]) * edge_nx[k]
              + (2 * longint'(vert_y[o]) - edge_my[k]) * edge_ny[k];
            edge_face[k] = (d > 0) ? FACING_POS : ((d < 0) ? FACING_NEG : FACING_ZERO);
        end
    endfunction

    function automatic void load_register(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_VERTEX_A_X: vert_x[0] = $signed(value[VERTEX_W-1:0]);
            REG_VERTEX_A_Y: vert_y[0] = $signed(value[VERTEX_W-1:0]);
            REG_VERTEX_B_X: vert_x[1] = $signed(value[VERTEX_W-1:0]);
            REG_VERTEX_B_Y: vert_y[1] = $signed(value[VERTEX_W-1:0]);
            REG_VERTEX_C_X: vert_x[2] = $signed(value[VERTEX_W-1:0]);
            REG_VERTEX_C_Y: vert_y[2] = $signed(value[VERTEX_W-1:0]);
            REG_FILL_COLOR: fill_rgba = value[COLOR_W-1:0];
            default: ;
        endcase
        derive_edge_setup();
    endfunction

    function automatic coverage_word_t predict_coverage(pixel_word_t w);
        coverage_word_t r;
        longint         t;
        logic           hit;
        hit = 1'b1;
        for (int k = 0; k < NUM_EDGES; k++) begin
            t = (2 * longint'(w.x) - edge_mx[k]) * edge_nx[k]
              + (2 * longint'(w.y) - edge_my[k]) * edge_ny[k];
            if ((edge_face[k] == FACING_POS && t < 0) || (edge_face[k] == FACING_NEG && t > 0))
                hit = 1'b0;
        end
        r.covered = hit;
        r.rgba    = hit ? fill_rgba : w.old_rgba;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        if (!calm && $urandom_range(99) < IDLE_PCT)
            repeat ($urandom_range(1, 3)) @(negedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        load_register(idx, value);
        cfg_writes++;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_triangle(input int ax, input int ay, input int bx, input int by,
                                input int cx, input int cy, input logic [COLOR_W-1:0] fill);
        write_reg(REG_VERTEX_A_X, {16'h0, 16'(ax)});
        write_reg(REG_VERTEX_A_Y, {16'h0, 16'(ay)});
        write_reg(REG_VERTEX_B_X, {16'h0, 16'(bx)});
        write_reg(REG_VERTEX_B_Y, {16'h0, 16'(by)});
        write_reg(REG_VERTEX_C_X, {16'h0, 16'(cx)});
        write_reg(REG_VERTEX_C_Y, {16'h0, 16'(cy)});
        write_reg(REG_FILL_COLOR, fill);
    endtask

    // mode 0: around the frame, 1: full 16-bit range, 2: coarse grid inside the frame
    task automatic random_triangle(input int mode);
        logic signed [VERTEX_W-1:0] c;
        for (int r = 0; r < 6; r++) begin
            case (mode)
                0:       c = VERTEX_W'($urandom_range(0, 8192) - 2048);
                1:       c = VERTEX_W'($urandom);
                default: c = VERTEX_W'($urandom_range(0, 8) * 512);
            endcase
            // upper data bits carry junk that must not matter
            write_reg(VERTEX_REGS[r], {16'($urandom), c});
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, $urandom);
        write_reg(REG_FILL_COLOR, $urandom);
    endtask

    function automatic logic [PIXEL_W-1:0] pick_coord(bit on_grid);
        if (on_grid)
            return PIXEL_W'($urandom_range(0, 64) * 64);
        if ($urandom_range(0, 9) == 0)
            return PIXEL_W'($urandom_range(0, 8191));
        return PIXEL_W'($urandom_range(0, 4096));
    endfunction

    task automatic queue_pixel(input int x, input int y, input logic [COLOR_W-1:0] old_rgba);
        pending_pixels.push_back('{PIXEL_W'(x), PIXEL_W'(y), old_rgba});
    endtask

    task automatic queue_random_pixels(input int count, input bit on_grid);
        for (int i = 0; i < count; i++)
            pending_pixels.push_back('{pick_coord(on_grid), pick_coord(on_grid), $urandom});
    endtask

    task automatic wait_idle();
        while (pending_pixels.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // pixel word sender
    always @(negedge clk) begin
        if (!rst_n)
            pix_in.valid <= 1'b0;
        else if (!pix_in.valid || pixel_taken) begin
            if (pending_pixels.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                pix_in.valid     <= 1'b1;
                pix_in.pixel_x   <= pending_pixels[0].x;
                pix_in.pixel_y   <= pending_pixels[0].y;
                pix_in.old_pixel <= pending_pixels[0].old_rgba;
            end
            else
                pix_in.valid <= 1'b0;
        end
    end

    // result receiver, with one long hold-off to back the pipeline up
    always @(negedge clk) begin
        if (!rst_n)
            pix_out.ready <= 1'b0;
        else if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            pix_out.ready <= 1'b0;
        end
        else if (!pressure_done && results_seen >= HOLD_OFF_AFTER) begin
            pressure_done = 1'b1;
            hold_cnt = HOLD_OFF_LEN - 1;
            pix_out.ready <= 1'b0;
        end
        else
            pix_out.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // checks results, then books the expectation for any pixel word taken this edge
    always @(posedge clk) begin
        pixel_taken <= rst_n && pix_in.valid && pix_in.ready;
        if (rst_n) begin
            if (pix_out.valid && pix_out.ready) begin
                out_word = '{pix_out.covered, pix_out.new_pixel};
                results_seen++;
                if (out_word.covered === 1'b1)
                    covered_seen++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected result word: covered=%b rgba=%08h",
                                 $realtime, out_word.covered, out_word.rgba);
                end
                else begin
                    want_word = expected_results.pop_front();
                    if (out_word.covered !== want_word.covered
                        || out_word.rgba !== want_word.rgba) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("[%0t] result %0d: expected covered=%b rgba=%08h, got covered=%b rgba=%08h",
                                     $realtime, results_seen, want_word.covered, want_word.rgba,
                                     out_word.covered, out_word.rgba);
                    end
                end
            end
            if (pix_in.valid && pix_in.ready) begin
                expected_results.push_back(predict_coverage('{pix_in.pixel_x, pix_in.pixel_y,
                                                              pix_in.old_pixel}));
                void'(pending_pixels.pop_front());
                pixels_sent++;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results still due",
                     quiet_cycles, expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int phase_mode [6];
        phase_mode = '{0, 1, 2, 0, 1, 2};
        rst_n            = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = '0;
        cfg_bus.data     = '0;
        pix_in.valid     = 1'b0;
        pix_in.pixel_x   = '0;
        pix_in.pixel_y   = '0;
        pix_in.old_pixel = '0;
        pix_out.ready    = 1'b0;
        pixel_taken      = 1'b0;
        calm             = 1'b0;
        pressure_done    = 1'b0;
        hold_cnt         = 0;
        quiet_cycles     = 0;
        fail_count       = 0;
        pixels_sent      = 0;
        results_seen     = 0;
        covered_seen     = 0;
        cfg_writes       = 0;
        vert_x           = '{0, 0, 0};
        vert_y           = '{0, 0, 0};
        fill_rgba        = '0;
        derive_edge_setup();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // after reset the triangle is degenerate, so everything is covered with black
        queue_pixel(0, 0, 32'hFFFF_FFFF);
        queue_pixel(4096, 4096, 32'h0000_0000);
        queue_pixel(8191, 8191, 32'hA5A5_5A5A);
        wait_idle();

        // right triangle in the frame: vertices, edge points, inside, outside, out of range
        set_triangle(0, 0, 4096, 0, 0, 4096, 32'hFFFF_FFFF);
        queue_pixel(0, 0, 32'h0000_0000);
        queue_pixel(4096, 0, 32'h0000_0000);
        queue_pixel(2048, 2048, 32'h0000_0000);
        queue_pixel(2048, 0, 32'h1234_5678);
        queue_pixel(1000, 1000, 32'h0000_0000);
        queue_pixel(3000, 3000, 32'h0000_0000);
        queue_pixel(8191, 8191, 32'hFFFF_FFFF);
        queue_pixel(0, 8191, 32'h8000_0001);
        wait_idle();

        // clockwise order at the extremes of the vertex range; diagonal y = x is an edge
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        set_triangle(-32768, -32768, -32768, 32767, 32767, 32767, 32'h0000_0000);
        queue_pixel(0, 4096, 32'hFFFF_FFFF);
        queue_pixel(4096, 0, 32'hFFFF_FFFF);
        queue_pixel(4096, 4096, 32'hFFFF_FFFF);
        queue_pixel(8191, 0, 32'hFFFF_FFFF);
        queue_pixel(0, 8191, 32'hFFFF_FFFF);
        wait_idle();

        // collinear, then coincident vertices: all edges pass
        set_triangle(0, 0, 1000, 1000, 2000, 2000, 32'h1234_5678);
        queue_pixel(4096, 0, 32'h0000_0000);
        queue_pixel(0, 4096, 32'h0000_0000);
        wait_idle();
        write_reg(REG_VERTEX_B_X, 32'h0000_0000);
        write_reg(REG_VERTEX_B_Y, 32'h0000_0000);
        queue_pixel(8191, 8191, 32'h0000_0000);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            calm = (ph == 3);
            random_triangle(phase_mode[ph]);
            queue_random_pixels(PHASE_ITEMS, phase_mode[ph] == 2);
            wait_idle();
        end
        calm = 1'b0;

        $display("sent %0d pixel words under %0d register writes; %0d results, %0d covered",
                 pixels_sent, cfg_writes, results_seen, covered_seen);
        $display("triangles: reset, in-frame, extreme clockwise, degenerate, 6 random setups");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
hdl/tpc_pkg.sv
hdl/tpc_ifs.sv
hdl/tpc_edge_setup.sv
hdl/triangle_pixel_coverage_top.sv
dv/tb_triangle_pixel_coverage_top.sv
